// File: design/imuca_pkg.sv
`default_nettype none
package imuca_pkg;

  // default values for the top level parameters
  localparam int CORDIC_STEPS_DEF = 24;
  localparam int ANGLE_FRAC_DEF   = 28;

  // datapath widths
  localparam int CW   = 52;  // cordic x / y, inputs scaled by 2^16 plus gain growth
  localparam int ZW   = 36;  // cordic angle accumulator, Q.32 radians
  localparam int MW   = 33;  // shared multiplier operand
  localparam int PW   = 66;  // multiplier product and accumulator
  localparam int ITW  = 5;   // cordic iteration index, up to 32 iterations
  localparam int CFGW = 19;  // config write data, widest register
  localparam int IDXW = 2;   // config register index

  // config register indexes
  localparam logic [IDXW-1:0] REG_BLEND   = 2'd0;
  localparam logic [IDXW-1:0] REG_GATE_LO = 2'd1;
  localparam logic [IDXW-1:0] REG_GATE_HI = 2'd2;

  // config reset values
  localparam logic [15:0] BLEND_RST   = 16'd64225;
  localparam logic [17:0] GATE_LO_RST = 18'd45875;
  localparam logic [18:0] GATE_HI_RST = 19'd85197;

  // fixed point constants
  localparam longint PI_Q32      = 64'sd13493037705;
  localparam longint HALF_PI_Q32 = 64'sd6746518852;
  localparam longint INV_GAIN    = 64'sd2608131496;
  localparam longint DEG_RAD     = 64'sd74961321;

  // datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RMUL_P,
    OP_RABS,
    OP_RMUL_LO,
    OP_ACC_SHR,
    OP_RMUL_HI,
    OP_RFIN,
    OP_CINIT,
    OP_CITER,
    OP_GMUL_LO,
    OP_GMUL_HI,
    OP_GFIN,
    OP_BMUL_W,
    OP_ACC_FULL,
    OP_BMUL_C,
    OP_BFIN,
    OP_UPDATE,
    OP_HOLD
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RMUL_P,
    S_RABS,
    S_RMUL_LO,
    S_RACC,
    S_RMUL_HI,
    S_RFIN,
    S_CINIT,
    S_CITER,
    S_GMUL_LO,
    S_GACC,
    S_GMUL_HI,
    S_GFIN,
    S_BMUL_W,
    S_BACC,
    S_BMUL_C,
    S_BFIN,
    S_WAIT
  } state_t;

  typedef struct packed {
    op_t            op;
    logic [1:0]     ax;    // axis for rate and blend steps
    logic [ITW-1:0] it;    // cordic iteration
    logic           pass;  // cordic pass: 0 roll, 1 pitch
  } cmd_t;

  typedef struct packed {
    logic dt_zero;
  } sts_t;

  // arctan(2^-i) in Q.32
  function automatic logic signed [ZW-1:0] atan_q32(input logic [ITW-1:0] i);
    logic signed [ZW-1:0] v;
    unique case (i)
      5'd0:  v = 36'sd3373259426;
      5'd1:  v = 36'sd1991351318;
      5'd2:  v = 36'sd1052175346;
      5'd3:  v = 36'sd534100635;
      5'd4:  v = 36'sd268086748;
      5'd5:  v = 36'sd134174063;
      5'd6:  v = 36'sd67103403;
      5'd7:  v = 36'sd33553749;
      5'd8:  v = 36'sd16777131;
      5'd9:  v = 36'sd8388597;
      5'd10: v = 36'sd4194303;
      5'd11: v = 36'sd2097152;
      5'd12: v = 36'sd1048576;
      5'd13: v = 36'sd524288;
      5'd14: v = 36'sd262144;
      5'd15: v = 36'sd131072;
      5'd16: v = 36'sd65536;
      5'd17: v = 36'sd32768;
      5'd18: v = 36'sd16384;
      5'd19: v = 36'sd8192;
      5'd20: v = 36'sd4096;
      5'd21: v = 36'sd2048;
      5'd22: v = 36'sd1024;
      5'd23: v = 36'sd512;
      5'd24: v = 36'sd256;
      5'd25: v = 36'sd128;
      5'd26: v = 36'sd64;
      5'd27: v = 36'sd32;
      5'd28: v = 36'sd16;
      5'd29: v = 36'sd8;
      5'd30: v = 36'sd4;
      5'd31: v = 36'sd2;
    endcase
    return v;
  endfunction

  // clamp to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: design/imuca_ctrl.sv
`default_nettype none
module imuca_ctrl
  import imuca_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire  clk,
  input  wire  rst,
  input  wire  in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire  out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [ITW-1:0] LAST_IT = ITW'(CORDIC_STEPS - 1);

  state_t         state;
  state_t         state_next;
  logic [1:0]     ax;
  logic [ITW-1:0] it;
  logic           pass;
  logic           slot_free;

  assign slot_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (in_valid) state_next = S_RMUL_P;
      S_RMUL_P:  state_next = sts.dt_zero ? S_WAIT : S_RABS;
      S_RABS:    state_next = S_RMUL_LO;
      S_RMUL_LO: state_next = S_RACC;
      S_RACC:    state_next = S_RMUL_HI;
      S_RMUL_HI: state_next = S_RFIN;
      S_RFIN:    state_next = (ax == 2'd2) ? S_CINIT : S_RMUL_P;
      S_CINIT:   state_next = S_CITER;
      S_CITER:   if (it == LAST_IT) state_next = S_GMUL_LO;
      S_GMUL_LO: state_next = S_GACC;
      S_GACC:    state_next = S_GMUL_HI;
      S_GMUL_HI: state_next = S_GFIN;
      S_GFIN:    state_next = pass ? S_BMUL_W : S_CINIT;
      S_BMUL_W:  state_next = S_BACC;
      S_BACC:    state_next = S_BMUL_C;
      S_BMUL_C:  state_next = S_BFIN;
      S_BFIN:    state_next = (ax == 2'd1) ? S_WAIT : S_BMUL_W;
      S_WAIT:    if (slot_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd.ax   = ax;
    cmd.it   = it;
    cmd.pass = pass;
    cmd.op   = OP_NONE;
    unique case (state)
      S_IDLE:    cmd.op = in_valid ? OP_LOAD : OP_NONE;
      S_RMUL_P:  cmd.op = OP_RMUL_P;
      S_RABS:    cmd.op = OP_RABS;
      S_RMUL_LO: cmd.op = OP_RMUL_LO;
      S_RACC:    cmd.op = OP_ACC_SHR;
      S_RMUL_HI: cmd.op = OP_RMUL_HI;
      S_RFIN:    cmd.op = OP_RFIN;
      S_CINIT:   cmd.op = OP_CINIT;
      S_CITER:   cmd.op = OP_CITER;
      S_GMUL_LO: cmd.op = OP_GMUL_LO;
      S_GACC:    cmd.op = OP_ACC_SHR;
      S_GMUL_HI: cmd.op = OP_GMUL_HI;
      S_GFIN:    cmd.op = OP_GFIN;
      S_BMUL_W:  cmd.op = OP_BMUL_W;
      S_BACC:    cmd.op = OP_ACC_FULL;
      S_BMUL_C:  cmd.op = OP_BMUL_C;
      S_BFIN:    cmd.op = OP_BFIN;
      S_WAIT: begin
        if (slot_free) cmd.op = sts.dt_zero ? OP_HOLD : OP_UPDATE;
      end
      default:   cmd.op = OP_NONE;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  // state, loop counters and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ax        <= '0;
      it        <= '0;
      pass      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE) begin
        ax   <= '0;
        it   <= '0;
        pass <= 1'b0;
      end
      if (state == S_RFIN) ax <= (ax == 2'd2) ? 2'd0 : ax + 2'd1;
      if (state == S_BFIN) ax <= ax + 2'd1;
      if (state == S_CITER) it <= (it == LAST_IT) ? '0 : it + 1'b1;
      if (state == S_GFIN) pass <= 1'b1;
      if (state == S_WAIT && slot_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/imuca_dp.sv
`default_nettype none
module imuca_dp
  import imuca_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     cfg_valid,
  input  wire        [IDXW-1:0]   cfg_index,
  input  wire        [CFGW-1:0]   cfg_data,
  input  wire signed [31:0]       accel_x,
  input  wire signed [31:0]       accel_y,
  input  wire signed [31:0]       accel_z,
  input  wire signed [31:0]       gyro_x,
  input  wire signed [31:0]       gyro_y,
  input  wire signed [31:0]       gyro_z,
  input  wire        [23:0]       time_step,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  output logic signed [31:0]      roll_angle,
  output logic signed [31:0]      pitch_angle,
  output logic signed [31:0]      yaw_angle,
  output logic                    sample_taken,
  output logic                    accel_used
);

  // angle format
  localparam int     SH        = 32 - ANGLE_FRAC_BITS;
  localparam int     RSH       = 39 - ANGLE_FRAC_BITS;
  localparam longint RND_ADD   = 64'sd1 <<< (SH - 1);
  localparam longint PI_A_L    = (PI_Q32 + RND_ADD) >>> SH;
  localparam logic signed [42:0] PI_INC  = 43'(PI_A_L);
  localparam logic signed [33:0] PI_YAW  = 34'(PI_A_L);
  localparam logic signed [33:0] TWO_PI  = 34'(2 * PI_A_L);
  localparam logic signed [MW-1:0] K_DEG = MW'(DEG_RAD);
  localparam logic signed [MW-1:0] K_INV = MW'(INV_GAIN);
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(HALF_PI_Q32);

  // configuration
  logic [15:0] blend_weight;
  logic [17:0] gate_lo;
  logic [18:0] gate_hi;

  // captured sample
  logic signed [31:0] ax_r, ay_r, az_r, gx_r, gy_r, gz_r;
  logic [23:0]        dt_r;

  // arithmetic state
  logic signed [PW-1:0] prod, acc;
  logic [55:0]          m;
  logic                 neg;
  logic signed [31:0]   roll_pred, pitch_pred, yinc_c;
  logic signed [CW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic                 zero;
  logic signed [ZW-1:0] ang0, ang1;
  logic [CW-1:0]        mag_yz;
  logic                 gate_ok;
  logic signed [31:0]   roll_bl, pitch_bl;
  logic signed [31:0]   roll_store, pitch_store, yaw_store;

  // combinational helpers
  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [31:0]   gsel, psel;
  logic signed [ZW-1:0] asel;
  logic signed [ZW:0]   rsum;
  logic signed [MW-1:0] ra;
  logic [CW-1:0]        xp;
  logic [16:0]          wc;
  logic signed [PW-1:0] tsum, tsh, r1;
  logic [41:0]          r;
  logic signed [42:0]   inc, inc_c;
  logic signed [CW-1:0] x0, y0, dx, dy;
  logic signed [PW-1:0] gsum, bsum;
  logic [CW-1:0]        magv;
  logic signed [31:0]   roll_sel, pitch_sel;
  logic signed [33:0]   ysum, ywrap;

  assign sts.dt_zero = (dt_r == '0);

  // operand selection
  always_comb begin
    unique case (cmd.ax)
      2'd0:    gsel = gx_r;
      2'd1:    gsel = gy_r;
      default: gsel = gz_r;
    endcase
    psel = (cmd.ax == 2'd0) ? roll_pred : pitch_pred;
    asel = (cmd.ax == 2'd0) ? ang0 : ang1;
    rsum = (ZW+1)'(asel) + (ZW+1)'(RND_ADD);
    ra   = MW'(rsum >>> SH);
    xp   = x[CW-1] ? '0 : x;
    wc   = 17'd65536 - {1'b0, blend_weight};
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_RMUL_P: begin
        mul_a = MW'(gsel);
        mul_b = {9'b0, dt_r};
      end
      OP_RMUL_LO: begin
        mul_a = {1'b0, m[31:0]};
        mul_b = K_DEG;
      end
      OP_RMUL_HI: begin
        mul_a = {9'b0, m[55:32]};
        mul_b = K_DEG;
      end
      OP_GMUL_LO: begin
        mul_a = {1'b0, xp[31:0]};
        mul_b = K_INV;
      end
      OP_GMUL_HI: begin
        mul_a = {13'b0, xp[CW-1:32]};
        mul_b = K_INV;
      end
      OP_BMUL_W: begin
        mul_a = {17'b0, blend_weight};
        mul_b = MW'(psel);
      end
      OP_BMUL_C: begin
        mul_a = {16'b0, wc};
        mul_b = ra;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // rate increment rounding, half away from zero
  always_comb begin
    tsum  = prod + acc;
    tsh   = tsum >>> RSH;
    r1    = (tsh + 66'sd1) >>> 1;
    r     = r1[41:0];
    inc   = neg ? -$signed({1'b0, r}) : $signed({1'b0, r});
    if (inc > PI_INC) begin
      inc_c = PI_INC;
    end else if (inc < -PI_INC) begin
      inc_c = -PI_INC;
    end else begin
      inc_c = inc;
    end
  end

  // cordic start vector and shifted terms
  always_comb begin
    if (cmd.pass) begin
      x0 = $signed(mag_yz);
      y0 = -(CW'($signed({ax_r, 16'b0})));
    end else begin
      x0 = CW'($signed({az_r, 16'b0}));
      y0 = CW'($signed({ay_r, 16'b0}));
    end
    dx = y >>> cmd.it;
    dy = x >>> cmd.it;
  end

  // gain, blend and final update terms
  always_comb begin
    gsum      = prod + acc;
    magv      = zero ? '0 : gsum[CW-1:0];
    bsum      = (acc + prod + 66'sd32768) >>> 16;
    roll_sel  = gate_ok ? roll_bl : roll_pred;
    pitch_sel = gate_ok ? pitch_bl : pitch_pred;
    ysum      = 34'(yaw_store) + 34'(yinc_c);
    if (ysum > PI_YAW) begin
      ywrap = ysum - TWO_PI;
    end else if (ysum < -PI_YAW) begin
      ywrap = ysum + TWO_PI;
    end else begin
      ywrap = ysum;
    end
  end

  // configuration registers and angle stores
  always_ff @(posedge clk) begin
    if (rst) begin
      blend_weight <= BLEND_RST;
      gate_lo      <= GATE_LO_RST;
      gate_hi      <= GATE_HI_RST;
      roll_store   <= '0;
      pitch_store  <= '0;
      yaw_store    <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_BLEND:   blend_weight <= cfg_data[15:0];
          REG_GATE_LO: gate_lo      <= cfg_data[17:0];
          REG_GATE_HI: gate_hi      <= cfg_data;
          default:     ;
        endcase
      end
      if (cmd.op == OP_UPDATE) begin
        roll_store  <= roll_sel;
        pitch_store <= pitch_sel;
        yaw_store   <= sat32(PW'(ywrap));
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      OP_LOAD: begin
        ax_r <= accel_x;
        ay_r <= accel_y;
        az_r <= accel_z;
        gx_r <= gyro_x;
        gy_r <= gyro_y;
        gz_r <= gyro_z;
        dt_r <= time_step;
      end
      OP_RABS: begin
        neg <= prod[PW-1];
        m   <= prod[PW-1] ? 56'(-prod) : prod[55:0];
      end
      OP_ACC_SHR:  acc <= prod >>> 32;
      OP_ACC_FULL: acc <= prod;
      OP_RFIN: begin
        unique case (cmd.ax)
          2'd0:    roll_pred  <= sat32(PW'(roll_store) + PW'(inc));
          2'd1:    pitch_pred <= sat32(PW'(pitch_store) + PW'(inc));
          default: yinc_c     <= 32'(inc_c);
        endcase
      end
      OP_CINIT: begin
        zero <= (x0 == '0) && (y0 == '0);
        if (x0 < 0) begin
          if (y0 >= 0) begin
            x <= y0;
            y <= -x0;
            z <= Z_HALF;
          end else begin
            x <= -y0;
            y <= x0;
            z <= -Z_HALF;
          end
        end else begin
          x <= x0;
          y <= y0;
          z <= '0;
        end
      end
      OP_CITER: begin
        if (y >= 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + atan_q32(cmd.it);
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - atan_q32(cmd.it);
        end
      end
      OP_GFIN: begin
        if (cmd.pass) begin
          ang1    <= zero ? '0 : z;
          gate_ok <= (magv[CW-1:16] > 36'(gate_lo)) && (magv[CW-1:16] < 36'(gate_hi));
        end else begin
          ang0   <= zero ? '0 : z;
          mag_yz <= magv;
        end
      end
      OP_BFIN: begin
        if (cmd.ax == 2'd0) begin
          roll_bl <= sat32(bsum);
        end else begin
          pitch_bl <= sat32(bsum);
        end
      end
      OP_UPDATE: begin
        roll_angle   <= roll_sel;
        pitch_angle  <= pitch_sel;
        yaw_angle    <= sat32(PW'(ywrap));
        sample_taken <= 1'b1;
        accel_used   <= gate_ok;
      end
      OP_HOLD: begin
        roll_angle   <= roll_store;
        pitch_angle  <= pitch_store;
        yaw_angle    <= yaw_store;
        sample_taken <= 1'b0;
        accel_used   <= 1'b0;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: design/imu_complementary_attitude_top.sv
`default_nettype none
// Complementary-filter attitude estimator. Each accepted sample (accel and gyro
// in Q16.16, time step in Q0.24 s) integrates the gyro rates into roll, pitch
// and yaw (Q4.28 rad at the default ANGLE_FRAC_BITS) and, when the accel
// magnitude lies strictly between the two gates, blends roll and pitch toward
// the accelerometer angles from a two-pass vectoring CORDIC. Yaw is wrapped to
// [-pi, pi]. One result follows every sample. The processing time is set by
// the CORDIC iterations and a single shared 33x33 multiplier stepped by the
// controller; out_valid rises when the wait state finds the output slot free.
// A zero time step skips the rate, CORDIC and blend steps and raises out_valid
// with the stored angles. The next sample can be taken in the cycle after the
// result is registered, even while that result still waits on out_stall.
// Config writes are always accepted and must be made while no sample is in
// flight.
module imu_complementary_attitude_top
  import imuca_pkg::*;
#(
  parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [IDXW-1:0]    cfg_index,
  input  wire  [CFGW-1:0]    cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  accel_x,
  input  wire signed [31:0]  accel_y,
  input  wire signed [31:0]  accel_z,
  input  wire signed [31:0]  gyro_x,
  input  wire signed [31:0]  gyro_y,
  input  wire signed [31:0]  gyro_z,
  input  wire        [23:0]  time_step,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] roll_angle,
  output logic signed [31:0] pitch_angle,
  output logic signed [31:0] yaw_angle,
  output logic               sample_taken,
  output logic               accel_used
);

  cmd_t cmd;
  sts_t sts;

  // config transfers never wait
  assign cfg_ready = 1'b1;

  imuca_ctrl #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  imuca_dp #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .accel_x     (accel_x),
    .accel_y     (accel_y),
    .accel_z     (accel_z),
    .gyro_x      (gyro_x),
    .gyro_y      (gyro_y),
    .gyro_z      (gyro_z),
    .time_step   (time_step),
    .cmd         (cmd),
    .sts         (sts),
    .roll_angle  (roll_angle),
    .pitch_angle (pitch_angle),
    .yaw_angle   (yaw_angle),
    .sample_taken(sample_taken),
    .accel_used  (accel_used)
  );

endmodule
`default_nettype wire
